/* hdl/rasr_pkg.sv */
// ----------------------------------------------------------------------------
// rasr_pkg
// Shared types and constants for the rational add/subtract/reduce block.
// ----------------------------------------------------------------------------
package rasr_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FIELD_W         = 32;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_SUB = 2'd1;

  // classified word handed from front to back; fractions are saturated,
  // sign-extended and carry a positive (or zero) denominator
  typedef struct packed {
    logic               is_add;
    logic               is_cmp;
    logic               bad;
    logic [FIELD_W-1:0] an;
    logic [FIELD_W-1:0] ad;
    logic [FIELD_W-1:0] bn;
    logic [FIELD_W-1:0] bd;
  } item_t;

endpackage

/* hdl/rational_add_sub_reduce_top.sv */
// ----------------------------------------------------------------------------
// rational_add_sub_reduce_top
// Adds, subtracts or compares two fractions and reduces the result by gcd.
//
//   channel  dir  handshake            fields
//   in       in   in_valid/in_stall    action first_num first_den
//                                      second_num second_den
//   out      out  out_valid/out_stall  result_num result_den is_equal
//                                      overflow bad_input
//
// One word at a time in the back end: multiplies in S_MUL1 to S_MUL3, a
// binary gcd loop, two restoring divides on one shared divider, plus
// control states. Zero denominators, compares and zero sums skip the gcd
// and the divides. A two-word queue keeps input accepted while the back
// end works or a result waits, until it fills; reset is synchronous and
// clears no memory.
// ----------------------------------------------------------------------------
module rational_add_sub_reduce_top import rasr_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                action,
  input  logic signed [FIELD_W-1:0] first_num,
  input  logic signed [FIELD_W-1:0] first_den,
  input  logic signed [FIELD_W-1:0] second_num,
  input  logic signed [FIELD_W-1:0] second_den,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [FIELD_W-1:0] result_num,
  output logic [FIELD_W-2:0]        result_den,
  output logic                      is_equal,
  output logic                      overflow,
  output logic                      bad_input
);

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  rasr_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .first_num  (first_num),
    .first_den  (first_den),
    .second_num (second_num),
    .second_den (second_den),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  rasr_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result_num (result_num),
    .result_den (result_den),
    .is_equal   (is_equal),
    .overflow   (overflow),
    .bad_input  (bad_input)
  );

endmodule

/* hdl/rasr_front.sv */
// ----------------------------------------------------------------------------
// rasr_front
// Accepts words, saturates and sign-normalizes the fractions, flags zero
// denominators and queues the classified word for the back end.
// ----------------------------------------------------------------------------
module rasr_front import rasr_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic [FIELD_W-1:0] first_num,
  input  logic [FIELD_W-1:0] first_den,
  input  logic [FIELD_W-1:0] second_num,
  input  logic [FIELD_W-1:0] second_den,
  output logic               q_valid,
  output item_t              q_item,
  input  logic               q_pop
);

  localparam int W  = VALUE_WIDTH;
  localparam int PW = $clog2(QUEUE_DEPTH);

  function automatic logic signed [W-1:0] sat(input logic [FIELD_W-1:0] raw);
    logic signed [W-1:0] v;
    v = signed'(raw[W-1:0]);
    if (v == signed'({1'b1, {(W-1){1'b0}}})) begin
      v = signed'({1'b1, {(W-2){1'b0}}, 1'b1});
    end
    return v;
  endfunction

  logic signed [W-1:0] an, ad, bn, bd;
  item_t               item;

  always_comb begin
    an = sat(first_num);
    ad = sat(first_den);
    bn = sat(second_num);
    bd = sat(second_den);
    if (ad[W-1]) begin
      an = -an;
      ad = -ad;
    end
    if (bd[W-1]) begin
      bn = -bn;
      bd = -bd;
    end
    item.is_add = (action == ACT_ADD);
    item.is_cmp = (action != ACT_ADD) && (action != ACT_SUB);
    item.bad    = (ad == '0) || (bd == '0);
    item.an     = FIELD_W'(an);
    item.ad     = FIELD_W'(ad);
    item.bn     = FIELD_W'(bn);
    item.bd     = FIELD_W'(bd);
  end

  item_t             ents [QUEUE_DEPTH];
  logic [PW-1:0]     wptr, rptr;
  logic [PW:0]       count;
  logic              push;

  assign in_stall = (count == (PW+1)'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_item   = ents[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ents[wptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (q_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/rasr_back.sv */
// ----------------------------------------------------------------------------
// rasr_back
// Sequencer: cross products on one shared multiplier, binary gcd, then
// restoring division of numerator and denominator, result register.
// ----------------------------------------------------------------------------
module rasr_back import rasr_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  item_t                     q_item,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [FIELD_W-1:0] result_num,
  output logic [FIELD_W-2:0]        result_den,
  output logic                      is_equal,
  output logic                      overflow,
  output logic                      bad_input
);

  localparam int W  = VALUE_WIDTH;
  localparam int MW = 2 * W;
  localparam int CW = $clog2(MW);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_MUL1 = 10'b0000000010,
    S_MUL2 = 10'b0000000100,
    S_MUL3 = 10'b0000001000,
    S_SUM  = 10'b0000010000,
    S_GCD  = 10'b0000100000,
    S_DIVN = 10'b0001000000,
    S_DIVD = 10'b0010000000,
    S_CHK  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t               state;
  logic signed [W-1:0]  an, ad, bn, bd;
  logic                 is_add, is_cmp;
  logic signed [MW-1:0] pa, pb;
  logic [MW-1:0]        pd;
  logic                 neg;
  logic [MW-1:0]        nmag;
  logic [MW-1:0]        x, y, g;
  logic [CW-1:0]        k;
  logic [MW-1:0]        dvd, rem, nq;
  logic [CW-1:0]        cnt;
  logic signed [W-1:0]  rn;
  logic [W-2:0]         rd;
  logic                 eq, ovf, bad;

  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [MW-1:0] prod;
  logic signed [MW:0]   sum;
  logic [MW-1:0]        smag;
  logic [MW:0]          trial;
  logic                 qbit;
  logic [MW-1:0]        lim;
  logic                 out_free;

  always_comb begin
    case (state)
      S_MUL1:  begin mul_a = an; mul_b = bd; end
      S_MUL2:  begin mul_a = bn; mul_b = ad; end
      default: begin mul_a = ad; mul_b = bd; end
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign sum   = is_add ? ({pa[MW-1], pa} + {pb[MW-1], pb})
                        : ({pa[MW-1], pa} - {pb[MW-1], pb});
  assign smag  = sum[MW] ? MW'(-sum) : sum[MW-1:0];
  assign trial = {rem, dvd[MW-1]};
  assign qbit  = (trial >= {1'b0, g});
  assign lim   = MW'({1'b0, {(W-1){1'b1}}});

  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (q_valid) state <= q_item.bad ? S_DONE : S_MUL1;
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_MUL3;
        S_MUL3: state <= S_SUM;
        S_SUM:  state <= (is_cmp || sum == '0) ? S_DONE : S_GCD;
        S_GCD:  if (x == y) state <= S_DIVN;
        S_DIVN: if (cnt == CW'(MW-1)) state <= S_DIVD;
        S_DIVD: if (cnt == CW'(MW-1)) state <= S_CHK;
        S_CHK:  state <= S_DONE;
        S_DONE: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        an     <= q_item.an[W-1:0];
        ad     <= q_item.ad[W-1:0];
        bn     <= q_item.bn[W-1:0];
        bd     <= q_item.bd[W-1:0];
        is_add <= q_item.is_add;
        is_cmp <= q_item.is_cmp;
        bad    <= q_item.bad;
        rn     <= '0;
        rd     <= (W-1)'(1);
        eq     <= 1'b0;
        ovf    <= 1'b0;
      end
      S_MUL1: pa <= prod;
      S_MUL2: pb <= prod;
      S_MUL3: pd <= prod;
      S_SUM: begin
        eq   <= is_cmp && (pa == pb);
        neg  <= sum[MW];
        nmag <= smag;
        x    <= smag;
        y    <= pd;
        k    <= '0;
      end
      S_GCD: begin
        if (x == y) begin
          g   <= x << k;
          dvd <= nmag;
          rem <= '0;
          cnt <= '0;
        end else if (!x[0] && !y[0]) begin
          x <= x >> 1;
          y <= y >> 1;
          k <= k + 1'b1;
        end else if (!x[0]) begin
          x <= x >> 1;
        end else if (!y[0]) begin
          y <= y >> 1;
        end else if (x > y) begin
          x <= (x - y) >> 1;
        end else begin
          y <= (y - x) >> 1;
        end
      end
      S_DIVN, S_DIVD: begin
        rem <= qbit ? MW'(trial - {1'b0, g}) : trial[MW-1:0];
        cnt <= cnt + 1'b1;
        if (state == S_DIVN && cnt == CW'(MW-1)) begin
          nq  <= {dvd[MW-2:0], qbit};
          dvd <= pd;
          rem <= '0;
          cnt <= '0;
        end else begin
          dvd <= {dvd[MW-2:0], qbit};
        end
      end
      S_CHK: begin
        if (nq > lim || dvd > lim) begin
          ovf <= 1'b1;
        end else begin
          rn <= neg ? -signed'(nq[W-1:0]) : signed'(nq[W-1:0]);
          rd <= dvd[W-2:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      result_num <= FIELD_W'(rn);
      result_den <= (FIELD_W-1)'(rd);
      is_equal   <= eq;
      overflow   <= ovf;
      bad_input  <= bad;
    end
  end

`ifndef SYNTHESIS
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (overflow || bad_input || is_equal) |->
      (result_num == '0 && result_den == (FIELD_W-1)'(1)))
    else $error("flagged result is not 0/1");
  a_flag_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(bad_input && (is_equal || overflow)))
    else $error("bad input combined with another flag");
  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result_den != '0)
    else $error("zero result denominator");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state != S_IDLE)
    else $error("word popped but sequencer stayed idle");
`endif

endmodule

/* test/rational_add_sub_reduce_top_test.sv */
// ----------------------------------------------------------------------------
// rational_add_sub_reduce_top_test
// Drives fraction add, subtract and compare words through the block, with
// random idle bursts on both channels, and checks every result word against
// a predictor built on exact 64-bit cross products and gcd reduction.
// ----------------------------------------------------------------------------
module rational_add_sub_reduce_top_test import rasr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_CMP = 2'd2;
  localparam logic [1:0] ACT_ANY = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam longint MAXMAG = 64'sd2147483647;

  typedef struct {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               eq;
    logic               ovf;
    logic               bad;
  } fraction_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic [1:0] action = '0;
  logic signed [FIELD_W-1:0] first_num = '0, first_den = 32'sd1;
  logic signed [FIELD_W-1:0] second_num = '0, second_den = 32'sd1;
  logic in_stall, out_valid, is_equal, overflow, bad_input;
  logic signed [FIELD_W-1:0] result_num;
  logic [FIELD_W-2:0] result_den;

  fraction_result_t pending_sums[$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;

  rational_add_sub_reduce_top dut (.*);

  always #5 clk = ~clk;

  function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic longint sat_field(logic [31:0] raw);
    longint v;
    v = longint'(signed'(raw));
    if (v < -MAXMAG) v = -MAXMAG;
    return v;
  endfunction

  function automatic void reduce(inout longint num, inout longint den);
    longint unsigned g;
    if (num == 0) begin
      den = 1;
      return;
    end
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    g = gcd64(num < 0 ? -num : num, den);
    num = num / longint'(g);
    den = den / longint'(g);
  endfunction

  function automatic fraction_result_t fraction_sum(logic [1:0] act, logic [31:0] an_r,
      logic [31:0] ad_r, logic [31:0] bn_r, logic [31:0] bd_r);
    fraction_result_t r;
    longint an, ad, bn, bd, s, sd;
    an = sat_field(an_r); ad = sat_field(ad_r);
    bn = sat_field(bn_r); bd = sat_field(bd_r);
    r = '{num: 0, den: 1, eq: 0, ovf: 0, bad: 0};
    if (ad == 0 || bd == 0) begin
      r.bad = 1'b1;
      return r;
    end
    reduce(an, ad);
    reduce(bn, bd);
    if (act == ACT_CMP || act == ACT_ANY) begin
      r.eq = (an == bn && ad == bd);
      return r;
    end
    s = (act == ACT_ADD) ? an * bd + bn * ad : an * bd - bn * ad;
    sd = ad * bd;
    reduce(s, sd);
    if (s > MAXMAG || s < -MAXMAG || sd > MAXMAG) r.ovf = 1'b1;
    else begin
      r.num = s[31:0];
      r.den = sd[30:0];
    end
    return r;
  endfunction

  task automatic send_word(logic [1:0] act, logic [31:0] an, logic [31:0] ad,
      logic [31:0] bn, logic [31:0] bd);
    int gap;
    if (!calm && $urandom_range(3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    first_num <= an; first_den <= ad;
    second_num <= bn; second_den <= bd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_sums.push_back(fraction_sum(act, an, ad, bn, bd));
  endtask

  always @(posedge clk) begin
    if (!rst)
      out_stall <= (!calm && $urandom_range(4) == 0) ? 1'b1 :
                   (out_stall && $urandom_range(1)) ? 1'b1 : 1'b0;
  end

  always @(posedge clk) begin
    fraction_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_sums.size() == 0) begin
        errors++;
        $display("%0t: unexpected word num=%0d den=%0d", $time, result_num, result_den);
      end else begin
        e = pending_sums.pop_front();
        if (result_num !== e.num || result_den !== e.den || is_equal !== e.eq ||
            overflow !== e.ovf || bad_input !== e.bad) begin
          errors++;
          $display("%0t: expected %0d/%0d eq=%b ovf=%b bad=%b, got %0d/%0d eq=%b ovf=%b bad=%b",
                   $time, e.num, e.den, e.eq, e.ovf, e.bad, result_num, result_den,
                   is_equal, overflow, bad_input);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return $urandom_range(0, 20) - 10;
      1: return $urandom_range(0, 2000) - 1000;
      2: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff} ^ $urandom_range(3);
      3: return $urandom_range(0, 65535) * ($urandom_range(1) ? 1 : -1);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] mx, mn;
    mx = 32'h7fff_ffff;
    mn = 32'h8000_0000;
    send_word(ACT_ADD, 1, 2, 1, 3);
    send_word(ACT_SUB, 1, 2, 1, 2);
    send_word(ACT_SUB, 3, -4, -5, 6);
    send_word(ACT_CMP, 2, 4, -1, -2);
    send_word(ACT_CMP, 1, 3, 1, 2);
    send_word(ACT_ANY, 0, 5, 0, -7);
    send_word(ACT_ADD, 1, 0, 1, 1);
    send_word(ACT_SUB, 1, 1, 1, 0);
    send_word(ACT_CMP, 0, 0, 0, 0);
    send_word(ACT_ADD, 0, -3, 0, 9);
    send_word(ACT_ADD, mx, 1, mx, 1);
    send_word(ACT_SUB, mn, 1, mx, 1);
    send_word(ACT_ADD, 1, mx, 1, mx - 1);
    send_word(ACT_SUB, mn, mn, mx, mx);
    send_word(ACT_CMP, mn, 1, -mx, 1);
    send_word(ACT_ADD, mx, mn, 1, 1);
    send_word(ACT_SUB, 32'hffff_ffff, 32'hffff_ffff, 0, 1);
    send_word(ACT_ANY, 6, 9, -4, -6);
  endtask

  task automatic test_random(int count);
    logic [31:0] an, ad, bn, bd, k;
    for (int i = 0; i < count; i++) begin
      an = rand_value(); ad = rand_value(); bn = rand_value(); bd = rand_value();
      if ($urandom_range(30) == 0) ad = 0;
      if ($urandom_range(30) == 0) bd = 0;
      if ($urandom_range(7) == 0) begin
        k = $urandom_range(1, 50);
        bn = an * k; bd = ad * k;
      end
      send_word(2'($urandom_range(3)), an, ad, bn, bd);
    end
  endtask

  task automatic test_drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_sums.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (300) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(500);
    calm = 1'b1;
    test_random(100);
    test_drain();
    if (errors == 0 && pending_sums.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
